// ===== sv/ordered_record_list_table_unit_assert.svh =====
// assertion macros shared by the record list table modules
`ifndef ORDERED_RECORD_LIST_TABLE_UNIT_ASSERT_SVH
`define ORDERED_RECORD_LIST_TABLE_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define ORLT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define ORLT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ORLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/orlt_pkg.sv =====
package orlt_pkg;

   // default sizes
   localparam int DEPTH_DEF      = 16;
   localparam int KEY_CHARS_DEF  = 8;
   localparam int NAME_CHARS_DEF = 8;

   // fixed field widths
   localparam int FIELD_W  = 64;
   localparam int REC_W    = 2 * FIELD_W;
   localparam int FILTER_W = 7;

   // character constants
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_OFFSET = CHAR_LOWER_A - CHAR_UPPER_A;
   localparam logic [FILTER_W-1:0] FILTER_RESET = CHAR_UPPER_A[FILTER_W-1:0];

   // operation codes
   typedef enum logic [1:0] {
      FUNC_INSERT   = 2'd0,
      FUNC_DEL_KEY  = 2'd1,
      FUNC_DEL_INIT = 2'd2,
      FUNC_DISPLAY  = 2'd3
   } func_type;

   // result status codes
   typedef enum logic [2:0] {
      STAT_DONE      = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_SHOWN     = 3'd4
   } stat_type;

   // controller to datapath
   typedef struct packed {
      logic     capture;
      logic     rd_issue;
      logic     sweep_en;
      logic     mode_key;
      logic     append;
      logic     commit;
      logic     out_load;
      logic     out_from_ram;
      stat_type out_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type func;
      logic     count_zero;
      logic     full;
      logic     rd_done;
      logic     rdata_vld;
      logic     found;
      logic     out_free;
   } stat_flags_type;

endpackage

// ===== sv/ordered_record_list_table_unit.sv =====
// Ordered record table of up to DEPTH key/name records kept compacted in one
// single-port-write, registered-read RAM. Operations arrive on req_ with the
// code in req_tuser; every operation gives one rsp_ beat with rsp_tlast set,
// except display of a non-empty table, which gives one beat per stored
// record (status shown) and sets rsp_tlast on the final one. Both deletes
// stream every stored entry through the RAM read port and write the
// survivors back through the write port, one entry a cycle. Display, with
// rsp_tready high, reads one entry and shows one record a cycle. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is accepted. No clearing pass is needed after reset. The
// filter letter for delete-by-initial is to be written on csr_ only while
// idle; the block itself does not enforce this.
module ordered_record_list_table_unit
   import orlt_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int KEY_CHARS  = KEY_CHARS_DEF,
   parameter int NAME_CHARS = NAME_CHARS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REC_W-1:0]    req_tdata,   // record_key, record_name
   input  logic [1:0]          req_tuser,   // func
   // response channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [REC_W-1:0]    rsp_tdata,   // shown_key, shown_name
   output logic [2:0]          rsp_tuser,   // status
   output logic                rsp_tlast,
   // filter letter register
   input  logic                csr_wr_en,
   input  logic [FILTER_W-1:0] csr_wr_data
);

   cmd_type        cmd;
   stat_flags_type flags;

   // sequencing
   orlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   // store, pointers and output register
   orlt_datapath #(
      .DEPTH      (DEPTH),
      .KEY_CHARS  (KEY_CHARS),
      .NAME_CHARS (NAME_CHARS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .flags       (flags),
      .req_func    (req_tuser),
      .req_key     (req_tdata[FIELD_W-1:0]),
      .req_name    (req_tdata[REC_W-1:FIELD_W]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== sv/orlt_ram.sv =====
module orlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port that holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/orlt_datapath.sv =====
module orlt_datapath
   import orlt_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int KEY_CHARS  = KEY_CHARS_DEF,
   parameter int NAME_CHARS = NAME_CHARS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_flags_type       flags,
   input  logic [1:0]           req_func,
   input  logic [FIELD_W-1:0]   req_key,
   input  logic [FIELD_W-1:0]   req_name,
   input  logic                 csr_wr_en,
   input  logic [FILTER_W-1:0]  csr_wr_data,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [REC_W-1:0]     rsp_tdata,
   output logic [2:0]           rsp_tuser,
   output logic                 rsp_tlast
);

`include "ordered_record_list_table_unit_assert.svh"

   // keep bytes up to the first zero byte or the char limit
   function automatic logic [FIELD_W-1:0] as_string(input logic [FIELD_W-1:0] v,
                                                   input int chars);
      logic [FIELD_W-1:0] r;
      logic               ended;
      r     = '0;
      ended = 1'b0;
      for (int i = 0; i < FIELD_W / 8; i++) begin
         if (i >= chars || v[8*i +: 8] == 8'h00) begin
            ended = 1'b1;
         end
         if (!ended) begin
            r[8*i +: 8] = v[8*i +: 8];
         end
      end
      return r;
   endfunction

   // initial letter match, either case when the filter is an upper-case letter
   function automatic logic initial_match(input logic [FIELD_W-1:0] name,
                                          input logic [FILTER_W-1:0] fl);
      logic [7:0] c;
      logic [7:0] f;
      logic       is_upper;
      c        = name[7:0];
      f        = {1'b0, fl};
      is_upper = (f >= CHAR_UPPER_A) && (f <= CHAR_UPPER_Z);
      return (c == f) || (is_upper && (c == f + LOWER_OFFSET));
   endfunction

   logic [FILTER_W-1:0] filter_ff;
   func_type            func_ff;
   logic [FIELD_W-1:0]  key_ff;
   logic [FIELD_W-1:0]  name_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]       wr_idx_ff, wr_idx_in;
   logic                found_ff, found_in;
   logic                rdata_vld_ff;
   logic                out_valid_ff, out_valid_in;
   logic [REC_W-1:0]    out_data_ff;
   stat_type            out_status_ff;
   logic                out_last_ff;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [REC_W-1:0]    ram_wr_data;
   logic [REC_W-1:0]    ram_rd_data;
   logic [FIELD_W-1:0]  rd_key;
   logic [FIELD_W-1:0]  rd_name;
   logic                drop;
   logic                sweep_beat;
   logic                out_free;
   logic                rd_done;

   // filter register
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= FILTER_RESET;
      end else if (csr_wr_en) begin
         filter_ff <= csr_wr_data;
      end
   end

   // request capture, fields normalized to string form
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= func_type'(req_func);
         key_ff  <= as_string(req_key, KEY_CHARS);
         name_ff <= as_string(req_name, NAME_CHARS);
      end
   end

   // sweep decision on the entry just read
   assign rd_key     = ram_rd_data[FIELD_W-1:0];
   assign rd_name    = ram_rd_data[REC_W-1:FIELD_W];
   assign drop       = cmd.mode_key ? ((rd_key == key_ff) && !found_ff)
                                    : initial_match(rd_name, filter_ff);
   assign sweep_beat = cmd.sweep_en && rdata_vld_ff;
   assign rd_done    = (rd_idx_ff == count_ff);

   // store write port: append at tail or write back a kept entry
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = {name_ff, key_ff};
      if (cmd.append) begin
         ram_wr_en = 1'b1;
      end else if (sweep_beat && !drop) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_idx_ff[AW-1:0];
         ram_wr_data = ram_rd_data;
      end
   end

   orlt_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // pointers, count and found flag
   always_comb begin
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      found_in  = found_ff;
      if (cmd.capture) begin
         rd_idx_in = '0;
         wr_idx_in = '0;
         found_in  = 1'b0;
      end
      if (cmd.rd_issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
      if (sweep_beat) begin
         if (!drop) begin
            wr_idx_in = wr_idx_ff + 1'b1;
         end else if (cmd.mode_key) begin
            found_in = 1'b1;
         end
      end
      if (cmd.append) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.commit) begin
         count_in = wr_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         found_ff     <= 1'b0;
         rdata_vld_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         found_ff     <= found_in;
         rdata_vld_ff <= cmd.rd_issue;
      end
   end

   // output register, free when empty or being taken
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= cmd.out_status;
         if (cmd.out_from_ram) begin
            out_data_ff <= ram_rd_data;
            out_last_ff <= rd_done;
         end else begin
            out_data_ff <= '0;
            out_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   // status toward the controller
   assign flags.func       = func_ff;
   assign flags.count_zero = (count_ff == '0);
   assign flags.full       = (count_ff == CW'(DEPTH));
   assign flags.rd_done    = rd_done;
   assign flags.rdata_vld  = rdata_vld_ff;
   assign flags.found      = found_ff;
   assign flags.out_free   = out_free;

   // checks
   `ORLT_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(DEPTH), "entry count above depth")
   `ORLT_ASSERT_ALWAYS(a_wr_behind_rd, wr_idx_ff <= rd_idx_ff, "write pointer passed read")
   `ORLT_ASSERT_IMPL(a_load_when_free, cmd.out_load, out_free, "result loaded over a beat")
   `ORLT_ASSERT_IMPL(a_no_read_past, cmd.rd_issue, !rd_done, "read beyond entry count")

endmodule

// ===== sv/orlt_ctrl.sv =====
module orlt_ctrl
   import orlt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  stat_flags_type flags,
   output cmd_type        cmd
);

`include "ordered_record_list_table_unit_assert.svh"

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_SWEEP  = 5'b00100,
      ST_DISP   = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   stat_type  resp_ff, resp_in;

   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in         = state_ff;
      resp_in          = resp_ff;
      cmd              = '0;
      cmd.out_status   = resp_ff;
      cmd.mode_key     = (flags.func == FUNC_DEL_KEY);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            case (flags.func)
               FUNC_INSERT: begin
                  if (flags.full) begin
                     resp_in = STAT_FULL;
                  end else begin
                     cmd.append = 1'b1;
                     resp_in    = STAT_DONE;
                  end
               end
               FUNC_DEL_KEY: begin
                  if (flags.count_zero) begin
                     resp_in = STAT_EMPTY;
                  end else begin
                     state_in = ST_SWEEP;
                  end
               end
               FUNC_DEL_INIT: begin
                  resp_in = STAT_DONE;
                  if (!flags.count_zero) begin
                     state_in = ST_SWEEP;
                  end
               end
               FUNC_DISPLAY: begin
                  if (flags.count_zero) begin
                     resp_in = STAT_EMPTY;
                  end else begin
                     cmd.rd_issue = 1'b1;
                     state_in     = ST_DISP;
                  end
               end
               default: begin
                  resp_in = STAT_DONE;
               end
            endcase
         end
         // read every entry once, write back the kept ones in order
         ST_SWEEP: begin
            cmd.sweep_en = 1'b1;
            cmd.rd_issue = !flags.rd_done;
            if (flags.rd_done && !flags.rdata_vld) begin
               cmd.commit = 1'b1;
               state_in   = ST_RESP;
               if (cmd.mode_key && !flags.found) begin
                  resp_in = STAT_NOT_FOUND;
               end else begin
                  resp_in = STAT_DONE;
               end
            end
         end
         // one shown record per free output beat
         ST_DISP: begin
            if (flags.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_from_ram = 1'b1;
               cmd.out_status   = STAT_SHOWN;
               if (flags.rd_done) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_issue = 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (flags.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         resp_ff  <= STAT_DONE;
      end else begin
         state_ff <= state_in;
         resp_ff  <= resp_in;
      end
   end

   // checks
   `ORLT_ASSERT_NEXT(a_accept_decodes, req_tvalid & req_tready, state_ff == ST_DECODE, "no decode")
   `ORLT_ASSERT_IMPL(a_ready_idle_only, req_tready, !cmd.out_load && !cmd.rd_issue, "not idle")
   `ORLT_ASSERT_IMPL(a_one_write_src, cmd.append, !cmd.sweep_en, "append during sweep")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import orlt_pkg::*;

   localparam int CLK_HALF    = 10;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD   = 400;
   localparam int REPORT_MAX  = 10;

   // one response beat as seen on rsp_
   typedef struct {
      stat_type    status;
      logic [63:0] key;
      logic [63:0] name;
      logic        last;
   } record_beat_type;

   // mirror of the record table plus the queue of beats still owed
   class record_table_checker;
      logic [63:0]     keys [DEPTH_DEF];
      logic [63:0]     names [DEPTH_DEF];
      int unsigned     count;
      logic [6:0]      letter;
      record_beat_type owed_beats[$];
      int              mismatches;

      function new();
         count      = 0;
         letter     = FILTER_RESET;
         mismatches = 0;
      endfunction

      function void set_letter(logic [6:0] l);
         letter = l;
      endfunction

      // string form: cut at first zero byte
      function logic [63:0] as_text(logic [63:0] v);
         logic [63:0] r;
         bit          ended;
         r     = '0;
         ended = 0;
         for (int i = 0; i < 8; i++) begin
            if (v[8*i +: 8] == 8'h00) ended = 1;
            if (!ended) r[8*i +: 8] = v[8*i +: 8];
         end
         return r;
      endfunction

      // case-insensitive only when the letter is upper-case
      function bit initial_hit(logic [63:0] nm);
         logic [7:0] c;
         c = nm[7:0];
         if (c == {1'b0, letter}) return 1;
         if ({1'b0, letter} >= CHAR_UPPER_A && {1'b0, letter} <= CHAR_UPPER_Z &&
             c == {1'b0, letter} + LOWER_OFFSET) return 1;
         return 0;
      endfunction

      function void owe(stat_type st, logic [63:0] k, logic [63:0] n, logic l);
         record_beat_type b;
         b.status = st;
         b.key    = k;
         b.name   = n;
         b.last   = l;
         owed_beats.push_back(b);
      endfunction

      // apply one accepted request and queue what it must produce
      function void note_request(func_type f, logic [63:0] k_raw, logic [63:0] n_raw);
         logic [63:0] k;
         logic [63:0] n;
         int          hit;
         int          w;
         k = as_text(k_raw);
         n = as_text(n_raw);
         case (f)
            FUNC_INSERT: begin
               if (count >= DEPTH_DEF) begin
                  owe(STAT_FULL, '0, '0, 1'b1);
               end else begin
                  keys[count]  = k;
                  names[count] = n;
                  count++;
                  owe(STAT_DONE, '0, '0, 1'b1);
               end
            end
            FUNC_DEL_KEY: begin
               hit = -1;
               for (int i = 0; i < count; i++)
                  if (hit < 0 && keys[i] == k) hit = i;
               if (count == 0) begin
                  owe(STAT_EMPTY, '0, '0, 1'b1);
               end else if (hit < 0) begin
                  owe(STAT_NOT_FOUND, '0, '0, 1'b1);
               end else begin
                  for (int j = hit; j + 1 < count; j++) begin
                     keys[j]  = keys[j+1];
                     names[j] = names[j+1];
                  end
                  count--;
                  owe(STAT_DONE, '0, '0, 1'b1);
               end
            end
            FUNC_DEL_INIT: begin
               w = 0;
               for (int i = 0; i < count; i++) begin
                  if (!initial_hit(names[i])) begin
                     keys[w]  = keys[i];
                     names[w] = names[i];
                     w++;
                  end
               end
               count = w;
               owe(STAT_DONE, '0, '0, 1'b1);
            end
            default: begin
               if (count == 0) begin
                  owe(STAT_EMPTY, '0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < count; i++)
                     owe(STAT_SHOWN, keys[i], names[i], (i + 1 == count));
               end
            end
         endcase
      endfunction

      // compare one accepted response beat with the oldest owed one
      function void check_response(logic [2:0] st, logic [63:0] k, logic [63:0] n,
                                   logic l);
         record_beat_type e;
         if (owed_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected beat: status %0d key %h name %h last %b",
                        st, k, n, l);
            return;
         end
         e = owed_beats.pop_front();
         if (st !== e.status || k !== e.key || n !== e.name || l !== e.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("beat mismatch: exp status %0d key %h name %h last %b, ",
                        e.status, e.key, e.name, e.last,
                        "got status %0d key %h name %h last %b", st, k, n, l);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REC_W-1:0]    req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [REC_W-1:0]    rsp_tdata;
   logic [2:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_wr_en;
   logic [FILTER_W-1:0] csr_wr_data;

   record_table_checker sb = new();

   int          burst_left;
   bit          gaps_on;
   int          rx_mode;
   int          hold_asks;
   int          hold_done;
   int          hold_left;
   logic [15:0] rx_pattern;
   int          rx_phase;
   int          cycles;

   ordered_record_list_table_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response beat check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[63:0], rsp_tdata[127:64], rsp_tlast);
   end

   // receiver: long hold on request, otherwise always ready or its own stall pattern
   always @(negedge clock) begin
      if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (rx_mode == 0) begin
         rsp_tready = 1'b1;
      end else begin
         rsp_tready = rx_pattern[rx_phase];
         rx_phase   = (rx_phase + 1) % 16;
         if (rx_phase == 0 && rx_mode == 2) rx_pattern = 16'($urandom);
      end
   end

   // build a zero-padded text field, first char in the low byte
   function automatic logic [63:0] text(string s);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   // fill the bytes after the terminator with junk
   function automatic logic [63:0] add_junk(logic [63:0] v);
      logic [63:0] r;
      bit          ended;
      r     = v;
      ended = 0;
      for (int i = 0; i < 8; i++) begin
         if (ended) r[8*i +: 8] = 8'($urandom);
         if (v[8*i +: 8] == 8'h00) ended = 1;
      end
      return r;
   endfunction

   function automatic logic [63:0] pool_key(int idx);
      logic [63:0] v;
      v = '0;
      for (int j = 0; j <= idx; j++) v[8*j +: 8] = 8'h41 + 8'(idx) + 8'(j);
      return v;
   endfunction

   function automatic logic [63:0] rand_key();
      int          pick;
      logic [63:0] v;
      pick = $urandom_range(0, 19);
      if (pick < 15)      v = pool_key($urandom_range(0, 7));
      else if (pick < 18) v = {$urandom, $urandom};
      else if (pick < 19) v = '1;
      else                v = '0;
      if ($urandom_range(0, 3) == 0) v = add_junk(v);
      return v;
   endfunction

   // names lean on the filter letter so bulk deletes find work
   function automatic logic [63:0] rand_name(logic [6:0] l);
      int          kind;
      int          len;
      logic [63:0] v;
      v    = '0;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: v[7:0] = {1'b0, l};
         3, 4:    v[7:0] = {1'b0, l} + LOWER_OFFSET;
         5, 6:    v[7:0] = CHAR_UPPER_A + 8'($urandom_range(0, 25));
         7:       v[7:0] = CHAR_LOWER_A + 8'($urandom_range(0, 25));
         8:       v[7:0] = 8'h00;
         default: v[7:0] = 8'($urandom_range(1, 255));
      endcase
      len = $urandom_range(0, 7);
      if (v[7:0] != 8'h00)
         for (int i = 1; i <= len; i++) v[8*i +: 8] = CHAR_LOWER_A + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 3) == 0) v = add_junk(v);
      return v;
   endfunction

   // offer one request beat, with burst gaps in front of a new burst
   task automatic send_item(func_type f, logic [63:0] k, logic [63:0] n);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = f;
      req_tdata  = {n, k};
      do @(posedge clock); while (!req_tready);
      sb.note_request(f, k, n);
      @(negedge clock);
   endtask

   // stop offering and wait until every owed beat has arrived
   task automatic drain();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (sb.owed_beats.size() != 0) @(negedge clock);
   endtask

   task automatic write_filter(logic [6:0] l);
      csr_wr_en   = 1'b1;
      csr_wr_data = l;
      @(posedge clock);
      sb.set_letter(l);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // mostly well-formed table traffic, some raw noise
   task automatic send_random();
      int       pick;
      func_type f;
      if ($urandom_range(0, 9) == 0) begin
         f = func_type'($urandom_range(0, 3));
         send_item(f, {$urandom, $urandom}, {$urandom, $urandom});
         return;
      end
      pick = $urandom_range(0, 99);
      if (sb.count < 4 && pick < 70) pick = 0;
      if (pick < 45)      f = FUNC_INSERT;
      else if (pick < 70) f = FUNC_DEL_KEY;
      else if (pick < 78) f = FUNC_DEL_INIT;
      else                f = FUNC_DISPLAY;
      send_item(f, rand_key(), rand_name(sb.letter));
   endtask

   logic [6:0] letters [7];

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = FUNC_INSERT;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = FILTER_RESET;
      burst_left  = 0;
      gaps_on     = 1;
      rx_mode     = 1;
      rx_pattern  = 16'hB6DB;
      rx_phase    = 0;
      hold_asks   = 0;
      hold_done   = 0;
      hold_left   = 0;
      cycles      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table cases
      send_item(FUNC_DISPLAY, '0, '0);
      send_item(FUNC_DEL_KEY, text("k1"), '0);
      send_item(FUNC_DEL_INIT, '1, '1);
      // field extremes and junk after the terminator
      send_item(FUNC_INSERT, '1, text("Alice"));
      send_item(FUNC_INSERT, '0, '0);
      send_item(FUNC_INSERT, 64'hA5A5_A5A5_0000_3141, 64'h7E7E_7E7E_006E_6E61);
      send_item(FUNC_INSERT, text("k1"), text("Bob"));
      send_item(FUNC_INSERT, text("k1"), text("bea"));
      send_item(FUNC_DISPLAY, '0, '0);
      // no match, match through junk, first of duplicate keys
      send_item(FUNC_DEL_KEY, text("zz"), '0);
      send_item(FUNC_DEL_KEY, 64'hFFFF_0000_0000_3141, '0);
      send_item(FUNC_DEL_KEY, text("k1"), '1);
      send_item(FUNC_DEL_INIT, '0, '0);
      send_item(FUNC_DISPLAY, '0, '0);
      // fill up, then insert into a full table
      while (sb.count < DEPTH_DEF)
         send_item(FUNC_INSERT, pool_key(sb.count % 8), rand_name(sb.letter));
      send_item(FUNC_INSERT, text("over"), text("flow"));
      send_item(FUNC_DISPLAY, '0, '0);
      send_item(FUNC_DEL_INIT, '0, '0);
      send_item(FUNC_DISPLAY, '0, '0);

      // random phases over filter settings and stall styles
      letters[0] = 7'h41;
      letters[1] = 7'h5A;
      letters[2] = 7'($urandom_range(65, 90));
      letters[3] = 7'h00;
      letters[4] = 7'h7F;
      letters[5] = 7'($urandom_range(65, 90));
      letters[6] = 7'h41;
      for (int p = 0; p < 7; p++) begin
         drain();
         write_filter(letters[p]);
         rx_mode = p % 3;
         gaps_on = (p != 1);
         if (p == 3) hold_asks++;
         for (int i = 0; i < 45; i++) send_random();
      end

      drain();
      repeat (DEPTH_DEF + 20) @(negedge clock);
      if (sb.mismatches == 0 && sb.owed_beats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== ordered_record_list_table_unit.f =====
+incdir+sv
sv/orlt_pkg.sv
sv/orlt_ram.sv
sv/orlt_datapath.sv
sv/orlt_ctrl.sv
sv/ordered_record_list_table_unit.sv
dv/tb_top.sv
